@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Immediate-consequence and next-cycle implication checks, clocked and
// disabled during reset. They compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LPIIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define LPIIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define LPIIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LPIIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/lpiir_pkg.sv @@
// ----------------------------------------------------------------------------
// lpiir_pkg
// Widths, register codes, reset values and shared types of the fourth-order
// low-pass IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none
package lpiir_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 28;
    localparam int COEF_W         = 32;
    localparam int GAIN_W         = COEF_W - 1;
    localparam int CLAMP_W        = SAMPLE_WIDTH - 1;
    localparam int OUT_FRAC       = 32;
    localparam int HIST_W         = SAMPLE_WIDTH + OUT_FRAC;
    localparam int HIST_DEPTH     = 4;
    localparam int HIST_IDX_W     = $clog2(HIST_DEPTH);
    localparam int SUM_W          = SAMPLE_WIDTH + 4;
    localparam int HALF_W         = HIST_W / 2;
    localparam int MB_W           = HALF_W + 1;
    localparam int PROD_W         = COEF_W + MB_W;
    localparam int ACC_W          = GAIN_W + SUM_W + OUT_FRAC + 4;
    localparam int SH_W           = ACC_W - COEF_FRAC_BITS;
    localparam int RES_W          = HIST_W + 1 - OUT_FRAC;
    localparam int LAST_STEP      = 2 * HIST_DEPTH;
    localparam int STEP_W         = $clog2(LAST_STEP + 1);
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_GAIN    = 3'd0,
        REG_DEN_A1      = 3'd1,
        REG_DEN_A2      = 3'd2,
        REG_DEN_A3      = 3'd3,
        REG_DEN_A4      = 3'd4,
        REG_CLAMP_LIMIT = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SHIFT_NONE,
        SHIFT_HALF,
        SHIFT_OUT
    } shift_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_SAT,
        ST_RND
    } state_t;

    typedef struct packed {
        logic [GAIN_W-1:0]                  num_gain;
        logic [HIST_DEPTH-1:0][COEF_W-1:0]  den_a;
        logic [CLAMP_W-1:0]                 clamp_limit;
    } cfg_t;

    typedef struct packed {
        logic               issue;
        logic               first;
        logic               neg;
        shift_t             shift;
        logic [COEF_W-1:0]  op_a;
        logic [MB_W-1:0]    op_b;
    } mac_op_t;

    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 31'd34856;
    localparam logic [COEF_W-1:0]  DEN_A1_RESET = -32'sd968487253;
    localparam logic [COEF_W-1:0]  DEN_A2_RESET = 32'sd1336666516;
    localparam logic [COEF_W-1:0]  DEN_A3_RESET = -32'sd835039268;
    localparam logic [COEF_W-1:0]  DEN_A4_RESET = 32'sd199050299;
    localparam logic [CLAMP_W-1:0] CLAMP_RESET  = 15'd32767;

    localparam cfg_t CFG_RESET = '{
        num_gain:    GAIN_RESET,
        den_a:       {DEN_A4_RESET, DEN_A3_RESET, DEN_A2_RESET, DEN_A1_RESET},
        clamp_limit: CLAMP_RESET
    };

endpackage
`default_nettype wire

@@ hw/rtl/lpiir_in_if.sv @@
// ----------------------------------------------------------------------------
// lpiir_in_if
// Input sample channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface lpiir_in_if;
    import lpiir_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lpiir_out_if.sv @@
// ----------------------------------------------------------------------------
// lpiir_out_if
// Filtered result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface lpiir_out_if;
    import lpiir_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           clipped;

    modport source (output valid, output filtered, output clipped, input ready);
    modport sink (input valid, input filtered, input clipped, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lpiir_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lpiir_cfg_if
// Configuration write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none
interface lpiir_cfg_if;
    import lpiir_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lpiir_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lpiir_cfg_regs
// Coefficient and clamp register file written through the configuration
// channel.
// ----------------------------------------------------------------------------
`default_nettype none
module lpiir_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    lpiir_cfg_if.sink       cfg,
    output lpiir_pkg::cfg_t regs
);
    import lpiir_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NUM_GAIN:    regs_next.num_gain    = cfg.data[GAIN_W-1:0];
                REG_DEN_A1:      regs_next.den_a[0]    = cfg.data[COEF_W-1:0];
                REG_DEN_A2:      regs_next.den_a[1]    = cfg.data[COEF_W-1:0];
                REG_DEN_A3:      regs_next.den_a[2]    = cfg.data[COEF_W-1:0];
                REG_DEN_A4:      regs_next.den_a[3]    = cfg.data[COEF_W-1:0];
                REG_CLAMP_LIMIT: regs_next.clamp_limit = cfg.data[CLAMP_W-1:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lpiir_mac.sv @@
// ----------------------------------------------------------------------------
// lpiir_mac
// Shared signed multiplier with a registered product, followed by a wide
// shift-and-accumulate stage.
// ----------------------------------------------------------------------------
`default_nettype none
module lpiir_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lpiir_pkg::mac_op_t                  op,
    output logic signed [lpiir_pkg::ACC_W-1:0]  acc
);
    import lpiir_pkg::*;

    logic signed [COEF_W-1:0] op_a_s;
    logic signed [MB_W-1:0]   op_b_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pvalid_reg;
    logic                     pfirst_reg;
    logic                     pneg_reg;
    shift_t                   pshift_reg;
    logic signed [ACC_W-1:0]  ext;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign op_a_s    = op.op_a;
    assign op_b_s    = op.op_b;
    assign prod_next = op_a_s * op_b_s;
    assign ext       = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc       = acc_reg;

    always_comb
    begin
        unique case (pshift_reg)
            SHIFT_NONE: term = ext;
            SHIFT_HALF: term = ext <<< HALF_W;
            SHIFT_OUT:  term = ext <<< OUT_FRAC;
            default:    term = ext;
        endcase
        base     = pfirst_reg ? '0 : acc_reg;
        acc_next = base + (pneg_reg ? ~term : term) + {{(ACC_W - 1){1'b0}}, pneg_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= op.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.issue)
        begin
            prod_reg   <= prod_next;
            pfirst_reg <= op.first;
            pneg_reg   <= op.neg;
            pshift_reg <= op.shift;
        end
        if (pvalid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lpiir_seq.sv @@
// ----------------------------------------------------------------------------
// lpiir_seq
// Sequencer: holds the sample histories, feeds the shared multiplier one
// partial product per cycle, then saturates, rounds and clamps the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lpiir_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    lpiir_in_if.sink                            din,
    lpiir_out_if.source                         dout,
    input  lpiir_pkg::cfg_t                     regs,
    output lpiir_pkg::mac_op_t                  mac_op,
    input  logic signed [lpiir_pkg::ACC_W-1:0]  acc
);
    import lpiir_pkg::*;

    state_t                         state_reg;
    state_t                         state_next;
    logic [STEP_W-1:0]              step_reg;
    logic [STEP_W-1:0]              step_next;
    logic [STEP_W-1:0]              step_m1;
    logic [HIST_IDX_W-1:0]          idx;
    logic signed [SAMPLE_WIDTH-1:0] x0_reg;
    logic signed [SAMPLE_WIDTH-1:0] xh_reg [HIST_DEPTH];
    logic signed [HIST_W-1:0]       yh_reg [HIST_DEPTH];
    logic signed [HIST_W-1:0]       yh_sel;
    logic signed [SUM_W-1:0]        s_sum;
    logic signed [SH_W-1:0]         t_sh;
    logic signed [HIST_W-1:0]       y_sat;
    logic signed [HIST_W-1:0]       y_reg;
    logic signed [HIST_W:0]         v_rnd;
    logic signed [RES_W-1:0]        r_rnd;
    logic signed [RES_W-1:0]        c_pos;
    logic signed [RES_W-1:0]        c_neg;
    logic signed [RES_W-1:0]        r_clamp;
    logic                           clip;
    logic signed [SAMPLE_WIDTH-1:0] lim_s;
    logic                           accept_in;
    logic                           hist_upd;
    logic                           load_out;
    logic                           ovalid_reg;
    logic                           ovalid_next;
    logic signed [SAMPLE_WIDTH-1:0] ofilt_reg;
    logic                           oclip_reg;

    assign din.ready     = (state_reg == ST_IDLE);
    assign accept_in     = din.valid && din.ready;
    assign dout.valid    = ovalid_reg;
    assign dout.filtered = ofilt_reg;
    assign dout.clipped  = oclip_reg;

    // The tap x0 + 4x1 + 6x2 + 4x3 + x4 of the binomial numerator.
    assign s_sum = SUM_W'(x0_reg) + (SUM_W'(xh_reg[0]) <<< 2)
                 + (SUM_W'(xh_reg[1]) <<< 2) + (SUM_W'(xh_reg[1]) <<< 1)
                 + (SUM_W'(xh_reg[2]) <<< 2) + SUM_W'(xh_reg[3]);

    assign step_m1 = step_reg - STEP_W'(1);
    assign idx     = step_m1[HIST_IDX_W:1];
    assign yh_sel  = yh_reg[idx];

    always_comb
    begin
        mac_op       = '0;
        mac_op.issue = (state_reg == ST_MUL);
        mac_op.first = (step_reg == '0);
        if (step_reg == '0)
        begin
            mac_op.neg   = 1'b0;
            mac_op.shift = SHIFT_OUT;
            mac_op.op_a  = {1'b0, regs.num_gain};
            mac_op.op_b  = MB_W'(s_sum);
        end
        else
        begin
            mac_op.neg  = 1'b1;
            mac_op.op_a = regs.den_a[idx];
            if (step_m1[0])
            begin
                mac_op.shift = SHIFT_HALF;
                mac_op.op_b  = {yh_sel[HIST_W-1], yh_sel[HIST_W-1:HALF_W]};
            end
            else
            begin
                mac_op.shift = SHIFT_NONE;
                mac_op.op_b  = {1'b0, yh_sel[HALF_W-1:0]};
            end
        end
    end

    // Floor to the history format, then saturate to its width.
    always_comb
    begin
        t_sh = acc[ACC_W-1:COEF_FRAC_BITS];
        if ((&t_sh[SH_W-1:HIST_W-1]) || !(|t_sh[SH_W-1:HIST_W-1]))
        begin
            y_sat = t_sh[HIST_W-1:0];
        end
        else if (t_sh[SH_W-1])
        begin
            y_sat = {1'b1, {(HIST_W - 1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(HIST_W - 1){1'b1}}};
        end
    end

    // Round half up to an integer, then clamp to the configured magnitude.
    always_comb
    begin
        v_rnd = {y_reg[HIST_W-1], y_reg}
              + {{(HIST_W - OUT_FRAC + 1){1'b0}}, 1'b1, {(OUT_FRAC - 1){1'b0}}};
        r_rnd = v_rnd[HIST_W:OUT_FRAC];
        c_pos = {{(RES_W - CLAMP_W){1'b0}}, regs.clamp_limit};
        c_neg = -c_pos;
        priority if (r_rnd > c_pos)
        begin
            r_clamp = c_pos;
            clip    = 1'b1;
        end
        else if (r_rnd < c_neg)
        begin
            r_clamp = c_neg;
            clip    = 1'b1;
        end
        else
        begin
            r_clamp = r_rnd;
            clip    = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        hist_upd   = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = ST_MUL;
                    step_next  = '0;
                end
            end
            ST_MUL:
            begin
                if (step_reg == STEP_W'(LAST_STEP))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                hist_upd   = 1'b1;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                if (!ovalid_reg || dout.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ovalid_next = load_out ? 1'b1 : (dout.ready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
            if (hist_upd)
            begin
                for (int i = HIST_DEPTH - 1; i > 0; i--)
                begin
                    xh_reg[i] <= xh_reg[i-1];
                    yh_reg[i] <= yh_reg[i-1];
                end
                xh_reg[0] <= x0_reg;
                yh_reg[0] <= y_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            x0_reg <= din.sample;
        end
        if (hist_upd)
        begin
            y_reg <= y_sat;
        end
        if (load_out)
        begin
            ofilt_reg <= r_clamp[SAMPLE_WIDTH-1:0];
            oclip_reg <= clip;
        end
    end

    assign lim_s = {1'b0, regs.clamp_limit};

    `LPIIR_ASSERT_IMP(a_step_range, clk, rst_n, state_reg == ST_MUL, step_reg <= STEP_W'(LAST_STEP))
    `LPIIR_ASSERT_NXT(a_drain_to_sat, clk, rst_n, state_reg == ST_DRAIN, state_reg == ST_SAT)
    `LPIIR_ASSERT_NXT(a_rnd_holds, clk, rst_n, state_reg == ST_RND && ovalid_reg && !dout.ready, state_reg == ST_RND)
    `LPIIR_ASSERT_IMP(a_clip_at_limit, clk, rst_n, ovalid_reg && oclip_reg, ofilt_reg == lim_s || ofilt_reg == -lim_s)

endmodule
`default_nettype wire

@@ hw/rtl/lowpass_iir_order4_top.sv @@
// A sample is taken only while idle and passes the multiply, drain, saturate and
// round states before its result is registered on the output. Its nine partial
// products pass one at a time through the single shared 32 x 25 multiplier.
// Reset: rst_n clears both histories, loads the default coefficients and
// clamp limit, and leaves the block idle and ready for a sample.
`default_nettype none
module lowpass_iir_order4_top (
    input  logic        clk,
    input  logic        rst_n,
    lpiir_in_if.sink    din,
    lpiir_out_if.source dout,
    lpiir_cfg_if.sink   cfg
);
    import lpiir_pkg::*;

    cfg_t                    regs;
    mac_op_t                 mac_op;
    logic signed [ACC_W-1:0] acc;

    lpiir_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    lpiir_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (acc)
    );

    lpiir_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (din),
        .dout   (dout),
        .regs   (regs),
        .mac_op (mac_op),
        .acc    (acc)
    );

endmodule
`default_nettype wire

@@ tb/lpiir_response_check.sv @@
// ----------------------------------------------------------------------------
// lpiir_response_check
// Watches the sample, result and configuration channels of the fourth-order
// low-pass IIR filter. Keeps its own copy of the coefficients and of both
// histories, works out the filtered value of every accepted sample and
// compares each accepted result with the oldest value still awaited.
// ----------------------------------------------------------------------------
module lpiir_response_check (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      sample_valid,
    input  logic                                      sample_ready,
    input  logic signed [lpiir_pkg::SAMPLE_WIDTH-1:0] sample,
    input  logic                                      result_valid,
    input  logic                                      result_ready,
    input  logic signed [lpiir_pkg::SAMPLE_WIDTH-1:0] filtered,
    input  logic                                      clipped,
    input  logic                                      cfg_valid,
    input  logic                                      cfg_ready,
    input  logic [lpiir_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [lpiir_pkg::CFG_DATA_W-1:0]          cfg_data,
    output int                                        outstanding,
    output int                                        mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpiir_pkg::*;

    localparam int WIDE_W      = 128;
    localparam int REPORT_MAX  = 10;
    localparam logic signed [WIDE_W-1:0] HIST_MAX = (128'sd1 <<< (HIST_W - 1)) - 128'sd1;
    localparam logic signed [WIDE_W-1:0] HIST_MIN = -(128'sd1 <<< (HIST_W - 1));

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered;
        logic                           clipped;
    } filter_out_t;

    filter_out_t                    awaited[$];
    logic [GAIN_W-1:0]              gain;
    logic signed [COEF_W-1:0]       den[HIST_DEPTH];
    logic [CLAMP_W-1:0]             clamp;
    logic signed [SAMPLE_WIDTH-1:0] x_hist[HIST_DEPTH];
    logic signed [HIST_W-1:0]       y_hist[HIST_DEPTH];
    int                             fail_total = 0;

    assign mismatches = fail_total;

    function automatic filter_out_t filter_sample(input logic signed [SAMPLE_WIDTH-1:0] x0);
        logic signed [WIDE_W-1:0] taps;
        logic signed [WIDE_W-1:0] acc;
        logic signed [HIST_W-1:0] y;
        logic signed [63:0]       wide_y;
        logic signed [63:0]       rounded;
        logic signed [63:0]       lim;
        filter_out_t              res;
        taps = x0 + 4 * x_hist[0] + 6 * x_hist[1] + 4 * x_hist[2] + x_hist[3];
        acc = $signed({1'b0, gain}) * taps;
        acc = acc <<< OUT_FRAC;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            acc = acc - den[i] * y_hist[i];
        end
        acc = acc >>> COEF_FRAC_BITS;
        if (acc > HIST_MAX)
        begin
            acc = HIST_MAX;
        end
        else if (acc < HIST_MIN)
        begin
            acc = HIST_MIN;
        end
        y = acc[HIST_W-1:0];
        for (int i = HIST_DEPTH - 1; i > 0; i--)
        begin
            x_hist[i] = x_hist[i-1];
            y_hist[i] = y_hist[i-1];
        end
        x_hist[0] = x0;
        y_hist[0] = y;
        wide_y = y;
        rounded = (wide_y + (64'sd1 <<< (OUT_FRAC - 1))) >>> OUT_FRAC;
        lim = clamp;
        res.clipped = 1'b0;
        if (rounded > lim)
        begin
            rounded = lim;
            res.clipped = 1'b1;
        end
        else if (rounded < -lim)
        begin
            rounded = -lim;
            res.clipped = 1'b1;
        end
        res.filtered = rounded[SAMPLE_WIDTH-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filter_out_t want;
        if (!rst_n)
        begin
            gain = GAIN_RESET;
            den[0] = DEN_A1_RESET;
            den[1] = DEN_A2_RESET;
            den[2] = DEN_A3_RESET;
            den[3] = DEN_A4_RESET;
            clamp = CLAMP_RESET;
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                x_hist[i] = '0;
                y_hist[i] = '0;
            end
            awaited.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NUM_GAIN:    gain = cfg_data[GAIN_W-1:0];
                    REG_DEN_A1:      den[0] = cfg_data;
                    REG_DEN_A2:      den[1] = cfg_data;
                    REG_DEN_A3:      den[2] = cfg_data;
                    REG_DEN_A4:      den[3] = cfg_data;
                    REG_CLAMP_LIMIT: clamp = cfg_data[CLAMP_W-1:0];
                    default:         ;
                endcase
            end
            if (sample_valid && sample_ready)
            begin
                awaited.push_back(filter_sample(sample));
            end
            if (result_valid && result_ready)
            begin
                if (awaited.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_MAX)
                    begin
                        $display("[%0t] unexpected result: filtered %0d clipped %0b",
                                 $time, filtered, clipped);
                    end
                end
                else
                begin
                    want = awaited.pop_front();
                    if (filtered !== want.filtered || clipped !== want.clipped)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_MAX)
                        begin
                            $display("[%0t] result mismatch: expected filtered %0d clipped %0b, got filtered %0d clipped %0b",
                                     $time, want.filtered, want.clipped, filtered, clipped);
                        end
                    end
                end
            end
            outstanding <= awaited.size();
        end
    end

endmodule

@@ tb/tb_lowpass_iir_order4_top.sv @@
// ----------------------------------------------------------------------------
// tb_lowpass_iir_order4_top
// Drives samples and coefficient writes into the low-pass IIR filter with
// bursty sender gaps and a stalling receiver, over several coefficient
// settings including overflow, zero clamp and register extremes, and lets
// the response checker judge every result.
// ----------------------------------------------------------------------------
module tb_lowpass_iir_order4_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpiir_pkg::*;

    localparam int LIMIT_CYCLES    = 200000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 95;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                           clk = 1'b0;
    logic                           rst_n;
    int                             outstanding;
    int                             mismatches;
    int unsigned                    cycle_count = 0;
    logic signed [SAMPLE_WIDTH-1:0] level = '0;
    logic [3:0]                     rx_slot = '0;
    logic [15:0]                    stall_mask = '1;

    lpiir_in_if  din_if ();
    lpiir_out_if dout_if ();
    lpiir_cfg_if cfg_if ();

    lowpass_iir_order4_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if),
        .cfg   (cfg_if)
    );

    lpiir_response_check response_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (din_if.valid),
        .sample_ready (din_if.ready),
        .sample       (din_if.sample),
        .result_valid (dout_if.valid),
        .result_ready (dout_if.ready),
        .filtered     (dout_if.filtered),
        .clipped      (dout_if.clipped),
        .cfg_valid    (cfg_if.valid),
        .cfg_ready    (cfg_if.ready),
        .cfg_index    (cfg_if.index),
        .cfg_data     (cfg_if.data),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("** lowpass_iir_order4_top: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (&rx_slot)
        begin
            case ($urandom_range(0, 3))
                0:       stall_mask <= '1;
                1:       stall_mask <= 16'($urandom);
                2:       stall_mask <= 16'($urandom) | 16'($urandom);
                default: ;
            endcase
        end
        rx_slot <= rx_slot + 1'b1;
        dout_if.ready <= stall_mask[rx_slot];
    end

    task automatic put_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
        din_if.valid <= 1'b1;
        din_if.sample <= value;
        do
            @(posedge clk);
        while (din_if.ready !== 1'b1);
    endtask

    task automatic pause_sender(input int gap);
        din_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic drain;
        din_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
    endtask

    task automatic apply_setting(input int phase);
        logic [CFG_DATA_W-1:0] v_gain;
        logic [CFG_DATA_W-1:0] v_clamp;
        logic [CFG_DATA_W-1:0] v_den[HIST_DEPTH];
        case (phase)
            1:
            begin
                v_gain = 32'hFFFF_FFFF;
                foreach (v_den[i]) v_den[i] = '0;
                v_clamp = 32'hFFFF_FFFF;
            end
            2:
            begin
                v_gain = '0;
                v_den[0] = 32'h7FFF_FFFF;
                v_den[1] = 32'h8000_0000;
                v_den[2] = 32'h7FFF_FFFF;
                v_den[3] = 32'h8000_0000;
                v_clamp = 32'hFFFF_8000;
            end
            3:
            begin
                v_gain = $urandom;
                v_gain[GAIN_W-1:0] = v_gain[GAIN_W-1:0] >> $urandom_range(6, 24);
                foreach (v_den[i]) v_den[i] = $signed($urandom) >>> $urandom_range(0, 6);
                v_clamp = $urandom;
            end
            4:
            begin
                v_gain = {1'b0, GAIN_RESET};
                v_den[0] = DEN_A1_RESET;
                v_den[1] = DEN_A2_RESET;
                v_den[2] = DEN_A3_RESET;
                v_den[3] = DEN_A4_RESET;
                v_clamp = 32'd100;
            end
            default:
            begin
                v_gain = 32'h0100_0000;
                v_den[0] = 32'hF800_0000;
                v_den[1] = '0;
                v_den[2] = '0;
                v_den[3] = '0;
                v_clamp = 32'd20000;
            end
        endcase
        write_reg(REG_NUM_GAIN, v_gain);
        write_reg(REG_DEN_A1, v_den[0]);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_DEN_A2, v_den[1]);
        write_reg(REG_DEN_A3, v_den[2]);
        write_reg(REG_DEN_A4, v_den[3]);
        write_reg(REG_CLAMP_LIMIT, v_clamp);
        write_reg(REG_SPARE_HI, $urandom);
        cfg_if.valid <= 1'b0;
    endtask

    // Mixes full-scale extremes, small values, held steps and wide noise.
    function automatic logic signed [SAMPLE_WIDTH-1:0] next_sample();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            1, 2:    return SAMPLE_WIDTH'($urandom_range(0, 127) - 64);
            3, 4, 5:
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    level = SAMPLE_WIDTH'($urandom);
                end
                return level;
            end
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    initial
    begin
        logic signed [SAMPLE_WIDTH-1:0] directed[$];
        int burst_left;
        rst_n <= 1'b0;
        din_if.valid <= 1'b0;
        din_if.sample <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                     16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh0000, 16'sh0000, 16'sh0000, 16'sh0001, 16'shFFFF,
                     16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA};
        foreach (directed[i])
        begin
            put_sample(directed[i]);
        end
        drain();

        burst_left = $urandom_range(1, 24);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                apply_setting(phase);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                put_sample(next_sample());
                if ($urandom_range(0, 39) == 0)
                begin
                    drain();
                end
                else if (burst_left == 0)
                begin
                    pause_sender($urandom_range(1, 20));
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 24);
                end
                else
                begin
                    burst_left--;
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("** lowpass_iir_order4_top: PASSED **");
        end
        else
        begin
            $display("** lowpass_iir_order4_top: FAILED **");
        end
        $finish;
    end

endmodule

@@ lowpass_iir_order4_top.f @@
+incdir+hw/rtl
hw/rtl/lpiir_pkg.sv
hw/rtl/lpiir_in_if.sv
hw/rtl/lpiir_out_if.sv
hw/rtl/lpiir_cfg_if.sv
hw/rtl/lpiir_cfg_regs.sv
hw/rtl/lpiir_mac.sv
hw/rtl/lpiir_seq.sv
hw/rtl/lowpass_iir_order4_top.sv
tb/lpiir_response_check.sv
tb/tb_lowpass_iir_order4_top.sv
